// File: hw/rtl/string_hash_four_byte_chunks_macros.svh
// assertion macros for the chunked string hash
`ifndef STRING_HASH_FOUR_BYTE_CHUNKS_MACROS_SVH
`define STRING_HASH_FOUR_BYTE_CHUNKS_MACROS_SVH

// same-cycle implication, checked outside reset
`define SH_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/shash_pkg.sv
// shared types, constants and microcode for the chunked string hash
package shash_pkg;

    localparam int LENGTH_BITS = 24;
    localparam int REMAIN_W    = 24;
    localparam int LEN_W       = (LENGTH_BITS < REMAIN_W) ? LENGTH_BITS : REMAIN_W;
    localparam int WORD_W      = 32;
    localparam int BYTE_W      = 8;
    localparam int STEP_W      = 3;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [STEP_W-1:0] step_t;

    // last microcode step of the body and mix programs
    localparam step_t BODY_LAST = 3'd6;
    localparam step_t MIX_LAST  = 3'd1;

    // largest remaining count that still marks the final chunk
    localparam int FINAL_MAX = 4;

    // zero-hash fallback on the length
    localparam word_t LEN_KEEP_MASK = 32'h00ff_ffff;
    localparam word_t LEN_FALLBACK  = 32'd11;

    // nibble weights for folding a value modulo 13 (16 is 3 mod 13)
    localparam logic [3:0] NIB_WEIGHT [0:7] = '{4'd1, 4'd3, 4'd9, 4'd1,
                                                4'd3, 4'd9, 4'd1, 4'd3};

    typedef enum logic [2:0] {
        OPA_ACC_ONE,
        OPA_ACC_TWO,
        OPA_LEN,
        OPA_B0,
        OPA_B1,
        OPA_B2,
        OPA_B3
    } opa_sel_t;

    typedef enum logic [1:0] {
        ADD_ZERO,
        ADD_X,
        ADD_Y,
        ADD_CONST
    } add_sel_t;

    typedef enum logic [1:0] {
        XOR_ZERO,
        XOR_X,
        XOR_Y
    } xor_sel_t;

    typedef enum logic [2:0] {
        DST_NONE,
        DST_X,
        DST_Y,
        DST_ACC_ONE,
        DST_ACC_TWO,
        DST_HASH
    } dst_sel_t;

    // one microcode word: r = (a * k + c) ^ d
    typedef struct packed {
        opa_sel_t opa;
        word_t    mul_k;
        add_sel_t addsel;
        word_t    add_k;
        xor_sel_t xsel;
        dst_sel_t dst;
    } uop_t;

    // operand values into the multiply-add-xor unit
    typedef struct packed {
        word_t mul_a;
        word_t mul_k;
        word_t addend;
        word_t mask;
    } mac_args_t;

    function automatic uop_t mk_uop(input opa_sel_t opa, input word_t mul_k,
                                    input add_sel_t addsel, input word_t add_k,
                                    input xor_sel_t xsel, input dst_sel_t dst);
        uop_t u;
        u.opa    = opa;
        u.mul_k  = mul_k;
        u.addsel = addsel;
        u.add_k  = add_k;
        u.xsel   = xsel;
        u.dst    = dst;
        return u;
    endfunction

    localparam uop_t UOP_IDLE = '{opa: OPA_ACC_ONE, mul_k: '0, addsel: ADD_ZERO,
                                  add_k: '0, xsel: XOR_ZERO, dst: DST_NONE};

    // body chunk: both accumulators from the old acc_two, the length and four bytes
    function automatic uop_t body_uop(input step_t step);
        uop_t u;
        case (step)
            3'd0: u = mk_uop(OPA_B0, 32'd307, ADD_ZERO, '0, XOR_ZERO, DST_X);
            3'd1: u = mk_uop(OPA_B1, 32'd1319, ADD_ZERO, '0, XOR_ZERO, DST_Y);
            3'd2: u = mk_uop(OPA_ACC_TWO, 32'd509, ADD_X, '0, XOR_Y, DST_ACC_ONE);
            3'd3: u = mk_uop(OPA_LEN, 32'd17, ADD_CONST, 32'd5, XOR_ZERO, DST_X);
            3'd4: u = mk_uop(OPA_ACC_TWO, 32'd5309, ADD_X, '0, XOR_ZERO, DST_X);
            3'd5: u = mk_uop(OPA_B2, 32'd3313, ADD_CONST, 32'd517, XOR_ZERO, DST_Y);
            3'd6: u = mk_uop(OPA_B3, 32'd9337, ADD_Y, '0, XOR_X, DST_ACC_TWO);
            default: u = UOP_IDLE;
        endcase
        return u;
    endfunction

    // final chunk tail cascade, two steps per valid byte
    function automatic uop_t tail_uop(input step_t step);
        uop_t u;
        case (step)
            3'd0: u = mk_uop(OPA_B0, 32'd503, ADD_ZERO, '0, XOR_ZERO, DST_Y);
            3'd1: u = mk_uop(OPA_ACC_ONE, 32'd7703, ADD_ZERO, '0, XOR_Y, DST_ACC_ONE);
            3'd2: u = mk_uop(OPA_B1, 32'd509, ADD_ZERO, '0, XOR_ZERO, DST_Y);
            3'd3: u = mk_uop(OPA_ACC_TWO, 32'd7717, ADD_ZERO, '0, XOR_Y, DST_ACC_TWO);
            3'd4: u = mk_uop(OPA_B2, 32'd523, ADD_CONST, 32'd11, XOR_ZERO, DST_Y);
            3'd5: u = mk_uop(OPA_ACC_ONE, 32'd9323, ADD_ZERO, '0, XOR_Y, DST_ACC_ONE);
            3'd6: u = mk_uop(OPA_B3, 32'd547, ADD_CONST, 32'd313, XOR_ZERO, DST_Y);
            3'd7: u = mk_uop(OPA_ACC_TWO, 32'd7727, ADD_CONST, 32'd127, XOR_Y, DST_ACC_TWO);
            default: u = UOP_IDLE;
        endcase
        return u;
    endfunction

    // final mix of both accumulators
    function automatic uop_t mix_uop(input step_t step);
        uop_t u;
        case (step)
            3'd0: u = mk_uop(OPA_ACC_ONE, 32'd29311, ADD_CONST, 32'd59, XOR_ZERO, DST_X);
            3'd1: u = mk_uop(OPA_ACC_TWO, 32'd7321, ADD_CONST, 32'd120501, XOR_X, DST_HASH);
            default: u = UOP_IDLE;
        endcase
        return u;
    endfunction

    // length modulo 13 by folding nibbles, then a short subtract chain
    function automatic logic [3:0] mod13(input logic [LEN_W-1:0] v);
        word_t      wide;
        logic [9:0] fold;
        logic [6:0] part;
        int         i;
        wide = WORD_W'(v);
        fold = '0;
        for (i = 0; i < 8; i++) begin
            fold = fold + 10'(wide[4*i +: 4]) * 10'(NIB_WEIGHT[i]);
        end
        part = 7'(fold[3:0]) + 7'(fold[7:4]) * 7'd3 + 7'(fold[9:8]) * 7'd9;
        if (part >= 7'd52) begin
            part = part - 7'd52;
        end
        if (part >= 7'd26) begin
            part = part - 7'd26;
        end
        if (part >= 7'd13) begin
            part = part - 7'd13;
        end
        return part[3:0];
    endfunction

endpackage

// File: hw/rtl/shash_mac.sv
// shared multiply-add-xor unit, 32-bit wrapping
module shash_mac (
    input  shash_pkg::mac_args_t args,
    output shash_pkg::word_t     result
);
    import shash_pkg::*;

    word_t product;

    // low word of the product, then add and xor
    assign product = word_t'(args.mul_a * args.mul_k);
    assign result  = (product + args.addend) ^ args.mask;

endmodule

// File: hw/rtl/string_hash_four_byte_chunks.sv
// top level of the chunked string hash
// Hashes a string delivered as four-byte chunks into a nonzero 32-bit value.
// Each accepted chunk is worked through one shared multiply-add-xor unit,
// one operation per cycle, under a microcoded sequencer; in_stall stays high
// until the chunk is done. A body chunk (more than four bytes remaining)
// works through seven unit operations before another chunk can be accepted.
// A final chunk with n valid bytes (0 to 4) takes two unit operations per byte
// of the tail cascade and two for the mix; it holds longer only while an
// earlier hash still sits unread in the output register. The hash is given
// on the output channel once per final chunk.
`include "string_hash_four_byte_chunks_macros.svh"

module string_hash_four_byte_chunks (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [shash_pkg::REMAIN_W-1:0]  remaining,
    input  logic                            first_chunk,
    input  logic [shash_pkg::BYTE_W-1:0]    byte_zero,
    input  logic [shash_pkg::BYTE_W-1:0]    byte_one,
    input  logic [shash_pkg::BYTE_W-1:0]    byte_two,
    input  logic [shash_pkg::BYTE_W-1:0]    byte_three,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [shash_pkg::WORD_W-1:0]    hash_value
);
    import shash_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_BODY,
        S_TAIL,
        S_MIX
    } state_t;

    typedef logic [BYTE_W-1:0] byte_t;

    state_t                 state_reg, state_next;
    step_t                  step_reg, step_next;
    word_t                  acc_one_reg, acc_one_next;
    word_t                  acc_two_reg, acc_two_next;
    logic [LENGTH_BITS-1:0] total_length_reg, total_length_next;
    word_t                  x_reg, x_next;
    word_t                  y_reg, y_next;
    logic [LEN_W-1:0]       len_reg, len_next;
    byte_t                  b0_reg, b0_next;
    byte_t                  b1_reg, b1_next;
    byte_t                  b2_reg, b2_next;
    byte_t                  b3_reg, b3_next;
    word_t                  hash_reg, hash_next;
    logic                   out_valid_reg, out_valid_next;

    logic             in_accept;
    logic [LEN_W-1:0] in_len;
    uop_t             uop;
    mac_args_t        mac_args;
    word_t            mac_result;
    word_t            hash_final;
    word_t            len_fallback;
    logic             out_free;
    logic             tail_last;

    assign in_stall   = (state_reg != S_IDLE);
    assign in_accept  = in_valid && !in_stall;
    assign in_len     = in_len_of(remaining);
    assign out_valid  = out_valid_reg;
    assign hash_value = hash_reg;
    assign out_free   = !out_valid_reg || !out_stall;

    function automatic logic [LEN_W-1:0] in_len_of(input logic [REMAIN_W-1:0] r);
        return r[LEN_W-1:0];
    endfunction

    function automatic word_t sext(input byte_t b);
        return {{(WORD_W-BYTE_W){b[BYTE_W-1]}}, b};
    endfunction

    // tail ends after two steps per valid byte
    assign tail_last = ({1'b0, step_reg} + 4'd1) == {len_reg[2:0], 1'b0};

    // microcode word for the current step
    always_comb
    begin
        case (state_reg)
            S_BODY:  uop = body_uop(step_reg);
            S_TAIL:  uop = tail_uop(step_reg);
            S_MIX:   uop = mix_uop(step_reg);
            default: uop = UOP_IDLE;
        endcase
    end

    // operand selection for the shared unit
    always_comb
    begin
        case (uop.opa)
            OPA_ACC_ONE: mac_args.mul_a = acc_one_reg;
            OPA_ACC_TWO: mac_args.mul_a = acc_two_reg;
            OPA_LEN:     mac_args.mul_a = WORD_W'(len_reg);
            OPA_B0:      mac_args.mul_a = sext(b0_reg);
            OPA_B1:      mac_args.mul_a = sext(b1_reg);
            OPA_B2:      mac_args.mul_a = sext(b2_reg);
            OPA_B3:      mac_args.mul_a = sext(b3_reg);
            default:     mac_args.mul_a = '0;
        endcase
        mac_args.mul_k = uop.mul_k;
        case (uop.addsel)
            ADD_X:     mac_args.addend = x_reg;
            ADD_Y:     mac_args.addend = y_reg;
            ADD_CONST: mac_args.addend = uop.add_k;
            default:   mac_args.addend = '0;
        endcase
        case (uop.xsel)
            XOR_X:   mac_args.mask = x_reg;
            XOR_Y:   mac_args.mask = y_reg;
            default: mac_args.mask = '0;
        endcase
    end

    shash_mac u_mac (
        .args   (mac_args),
        .result (mac_result)
    );

    // zero hash falls back to acc_one, acc_two, then the length
    assign len_fallback = (WORD_W'(total_length_reg) & LEN_KEEP_MASK) + LEN_FALLBACK;
    assign hash_final   = (mac_result != '0)  ? mac_result  :
                          (acc_one_reg != '0) ? acc_one_reg :
                          (acc_two_reg != '0) ? acc_two_reg : len_fallback;

    // sequencer and datapath next values
    always_comb
    begin
        state_next        = state_reg;
        step_next         = step_reg;
        acc_one_next      = acc_one_reg;
        acc_two_next      = acc_two_reg;
        total_length_next = total_length_reg;
        x_next            = x_reg;
        y_next            = y_reg;
        len_next          = len_reg;
        b0_next           = b0_reg;
        b1_next           = b1_reg;
        b2_next           = b2_reg;
        b3_next           = b3_reg;
        hash_next         = hash_reg;
        out_valid_next    = out_valid_reg && out_stall;

        // unit writeback, except the hash which waits for a free output
        case (uop.dst)
            DST_X:       x_next       = mac_result;
            DST_Y:       y_next       = mac_result;
            DST_ACC_ONE: acc_one_next = mac_result;
            DST_ACC_TWO: acc_two_next = mac_result;
            default:     ;
        endcase

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    len_next  = in_len;
                    b0_next   = byte_zero;
                    b1_next   = byte_one;
                    b2_next   = byte_two;
                    b3_next   = byte_three;
                    step_next = '0;
                    if (first_chunk)
                    begin
                        acc_one_next      = WORD_W'(mod13(in_len));
                        acc_two_next      = WORD_W'(in_len);
                        total_length_next = LENGTH_BITS'(in_len);
                    end
                    if (in_len > LEN_W'(FINAL_MAX))
                    begin
                        state_next = S_BODY;
                    end
                    else if (in_len == '0)
                    begin
                        state_next = S_MIX;
                    end
                    else
                    begin
                        state_next = S_TAIL;
                    end
                end
            end
            S_BODY:
            begin
                if (step_reg == BODY_LAST)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    step_next = step_reg + 3'd1;
                end
            end
            S_TAIL:
            begin
                if (tail_last)
                begin
                    state_next = S_MIX;
                    step_next  = '0;
                end
                else
                begin
                    step_next = step_reg + 3'd1;
                end
            end
            S_MIX:
            begin
                if (step_reg != MIX_LAST)
                begin
                    step_next = step_reg + 3'd1;
                end
                else if (out_free)
                begin
                    hash_next      = hash_final;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            step_reg         <= '0;
            acc_one_reg      <= '0;
            acc_two_reg      <= '0;
            total_length_reg <= '0;
            x_reg            <= '0;
            y_reg            <= '0;
            len_reg          <= '0;
            b0_reg           <= '0;
            b1_reg           <= '0;
            b2_reg           <= '0;
            b3_reg           <= '0;
            hash_reg         <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            step_reg         <= step_next;
            acc_one_reg      <= acc_one_next;
            acc_two_reg      <= acc_two_next;
            total_length_reg <= total_length_next;
            x_reg            <= x_next;
            y_reg            <= y_next;
            len_reg          <= len_next;
            b0_reg           <= b0_next;
            b1_reg           <= b1_next;
            b2_reg           <= b2_next;
            b3_reg           <= b3_next;
            hash_reg         <= hash_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // checks on sequencing and the result
    `SH_ASSERT_NOW(a_hash_nonzero, out_valid, hash_value != '0, "hash output is zero")
    `SH_ASSERT_NOW(a_result_from_mix, $rose(out_valid), $past(state_reg == S_MIX), "result not from mix")
    `SH_ASSERT_NEXT(a_body_entry, in_accept && (in_len > LEN_W'(FINAL_MAX)), state_reg == S_BODY, "body chunk not sequenced")
    `SH_ASSERT_NOW(a_body_step_range, state_reg == S_BODY, step_reg <= BODY_LAST, "body step out of range")

endmodule

// File: test/string_hash_checker.sv
// checker for the chunked string hash: predicts each hash and compares it on the output channel
module string_hash_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic [shash_pkg::REMAIN_W-1:0] remaining,
    input  logic                           first_chunk,
    input  logic [shash_pkg::BYTE_W-1:0]   byte_zero,
    input  logic [shash_pkg::BYTE_W-1:0]   byte_one,
    input  logic [shash_pkg::BYTE_W-1:0]   byte_two,
    input  logic [shash_pkg::BYTE_W-1:0]   byte_three,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic [shash_pkg::WORD_W-1:0]   hash_value,
    output int                             mismatch_count,
    output int                             hashes_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import shash_pkg::*;

    // predicted state of the hash, zero at start
    word_t            pred_acc_one  = '0;
    word_t            pred_acc_two  = '0;
    logic [LEN_W-1:0] pred_length   = '0;
    word_t            expected_hashes[$];

    initial begin
        mismatch_count = 0;
        hashes_pending = 0;
    end

    // a byte lane read as a signed value
    function automatic word_t widen_signed(input logic [BYTE_W-1:0] b);
        return {{(WORD_W-BYTE_W){b[BYTE_W-1]}}, b};
    endfunction

    // fold one chunk into the predicted accumulators, queue a hash on the final chunk
    task automatic absorb_chunk(input logic [REMAIN_W-1:0] rem, input logic first,
                                input logic [BYTE_W-1:0] c0, input logic [BYTE_W-1:0] c1,
                                input logic [BYTE_W-1:0] c2, input logic [BYTE_W-1:0] c3);
        word_t len_now;
        word_t s0;
        word_t s1;
        word_t s2;
        word_t s3;
        word_t old_two;
        word_t h;
        len_now = WORD_W'(rem[LEN_W-1:0]);
        s0 = widen_signed(c0);
        s1 = widen_signed(c1);
        s2 = widen_signed(c2);
        s3 = widen_signed(c3);

        // first chunk seeds from the length
        if (first) begin
            pred_acc_one = len_now % 32'd13;
            pred_acc_two = len_now;
            pred_length  = rem[LEN_W-1:0];
        end

        // body chunk
        if (len_now > 32'd4) begin
            old_two = pred_acc_two;
            pred_acc_one = (32'd509 * old_two + 32'd307 * s0) ^ (32'd1319 * s1);
            pred_acc_two = (32'd17 * len_now + 32'd5 + 32'd5309 * old_two)
                           ^ (32'd3313 * s2 + 32'd9337 * s3 + 32'd517);
        end else begin
            // tail cascade over the valid lanes
            if (len_now > 32'd0) begin
                pred_acc_one = (pred_acc_one * 32'd7703) ^ (32'd503 * s0);
            end
            if (len_now > 32'd1) begin
                pred_acc_two = (pred_acc_two * 32'd7717) ^ (32'd509 * s1);
            end
            if (len_now > 32'd2) begin
                pred_acc_one = (pred_acc_one * 32'd9323) ^ (32'd11 + 32'd523 * s2);
            end
            if (len_now > 32'd3) begin
                pred_acc_two = (pred_acc_two * 32'd7727 + 32'd127) ^ (32'd313 + 32'd547 * s3);
            end

            // final mix with the zero fallbacks
            h = (pred_acc_one * 32'd29311 + 32'd59) ^ (pred_acc_two * 32'd7321 + 32'd120501);
            if (h == '0) begin
                h = pred_acc_one;
            end
            if (h == '0) begin
                h = pred_acc_two;
            end
            if (h == '0) begin
                h = (WORD_W'(pred_length) & 32'h00ff_ffff) + 32'd11;
            end
            expected_hashes.push_back(h);
        end
    endtask

    // watch both channels at each rising edge
    always @(posedge clk) begin
        word_t want;
        if (rst_n) begin
            // results first: an item accepted in this cycle cannot have produced one yet
            if (out_valid && !out_stall) begin
                if (expected_hashes.size() == 0) begin
                    $display("%0t: unexpected hash, expected none, actual %08h",
                             $time, hash_value);
                    mismatch_count = mismatch_count + 1;
                end else begin
                    want = expected_hashes.pop_front();
                    if (hash_value !== want) begin
                        $display("%0t: hash_value mismatch, expected %08h, actual %08h",
                                 $time, want, hash_value);
                        mismatch_count = mismatch_count + 1;
                    end
                end
            end
            if (in_valid && !in_stall) begin
                absorb_chunk(remaining, first_chunk, byte_zero, byte_one, byte_two,
                             byte_three);
            end
            hashes_pending = expected_hashes.size();
        end
    end

endmodule

// File: test/tb.sv
// testbench top for the chunked string hash: stimulus, stalls, watchdog and verdict
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import shash_pkg::*;

    localparam int TARGET_ITEMS = 1650;
    localparam int STALL_LIMIT  = 1000;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [REMAIN_W-1:0] remaining = '0;
    logic                first_chunk = 1'b0;
    logic [BYTE_W-1:0]   byte_zero = '0;
    logic [BYTE_W-1:0]   byte_one = '0;
    logic [BYTE_W-1:0]   byte_two = '0;
    logic [BYTE_W-1:0]   byte_three = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [WORD_W-1:0]   hash_value;

    int mismatch_count;
    int hashes_pending;
    int chunks_sent = 0;
    int quiet_cycles = 0;
    bit no_idle = 1'b0;

    string_hash_four_byte_chunks u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .remaining   (remaining),
        .first_chunk (first_chunk),
        .byte_zero   (byte_zero),
        .byte_one    (byte_one),
        .byte_two    (byte_two),
        .byte_three  (byte_three),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .hash_value  (hash_value)
    );

    string_hash_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .remaining      (remaining),
        .first_chunk    (first_chunk),
        .byte_zero      (byte_zero),
        .byte_one       (byte_one),
        .byte_two       (byte_two),
        .byte_three     (byte_three),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .hash_value     (hash_value),
        .mismatch_count (mismatch_count),
        .hashes_pending (hashes_pending)
    );

    // 10 ns clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // random back-pressure on the hash output
    always @(negedge clk) begin
        out_stall <= !no_idle && ($urandom_range(99) < 10);
    end

    // watchdog on cycles with no transfer on either channel
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles = quiet_cycles + 1;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // drive one chunk from a falling edge, return at the falling edge after acceptance
    task automatic send_chunk(input logic [REMAIN_W-1:0] rem, input logic first,
                              input logic [BYTE_W-1:0] c0, input logic [BYTE_W-1:0] c1,
                              input logic [BYTE_W-1:0] c2, input logic [BYTE_W-1:0] c3);
        int gap;
        gap = 0;
        if (!no_idle && $urandom_range(99) < 10) begin
            gap = $urandom_range(3, 1);
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        remaining   <= rem;
        first_chunk <= first;
        byte_zero   <= c0;
        byte_one    <= c1;
        byte_two    <= c2;
        byte_three  <= c3;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
        chunks_sent = chunks_sent + 1;
    endtask

    // a consistent string of the given length with random content
    task automatic send_string(input int unsigned len);
        logic [REMAIN_W-1:0] rem;
        logic                first;
        rem = REMAIN_W'(len);
        first = 1'b1;
        forever begin
            send_chunk(rem, first, BYTE_W'($urandom), BYTE_W'($urandom),
                       BYTE_W'($urandom), BYTE_W'($urandom));
            first = 1'b0;
            if (rem <= REMAIN_W'(FINAL_MAX)) begin
                break;
            end
            rem = rem - REMAIN_W'(4);
        end
    endtask

    // a string that starts at a large length and jumps to its final chunk
    task automatic send_truncated(input logic [REMAIN_W-1:0] start_len, input int bodies);
        logic [REMAIN_W-1:0] rem;
        int                  i;
        rem = start_len;
        for (i = 0; i < bodies; i++) begin
            send_chunk(rem, i == 0, BYTE_W'($urandom), BYTE_W'($urandom),
                       BYTE_W'($urandom), BYTE_W'($urandom));
            rem = rem - REMAIN_W'(4);
        end
        send_chunk(REMAIN_W'($urandom_range(FINAL_MAX)), 1'b0, BYTE_W'($urandom),
                   BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom));
    endtask

    initial begin
        int pick;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: body and final chunks before any first chunk
        send_chunk(REMAIN_W'(8), 1'b0, 8'hff, 8'h80, 8'h7f, 8'h00);
        send_chunk(REMAIN_W'(3), 1'b0, 8'h80, 8'h7f, 8'hff, 8'h01);
        // directed: final sizes zero to three, and the first body sizes
        send_string(0);
        send_string(1);
        send_string(2);
        send_string(3);
        send_string(5);
        send_string(9);
        // directed: byte extremes on a full final chunk
        send_chunk(REMAIN_W'(4), 1'b1, 8'hff, 8'hff, 8'hff, 8'hff);
        send_chunk(REMAIN_W'(4), 1'b1, 8'h00, 8'h00, 8'h00, 8'h00);
        send_chunk(REMAIN_W'(4), 1'b1, 8'h80, 8'h80, 8'h80, 8'h80);
        send_chunk(REMAIN_W'(4), 1'b1, 8'h7f, 8'h7f, 8'h7f, 8'h7f);
        // directed: largest length, then an inconsistent jump to the tail
        send_chunk({REMAIN_W{1'b1}}, 1'b1, 8'h80, 8'h80, 8'h80, 8'h80);
        send_chunk(REMAIN_W'(4), 1'b0, 8'h7f, 8'h7f, 8'h7f, 8'h7f);
        // directed: empty final chunk without a first chunk
        send_chunk(REMAIN_W'(0), 1'b0, 8'hff, 8'h00, 8'hff, 8'h00);

        // random strings, mostly well formed
        while (chunks_sent < TARGET_ITEMS) begin
            no_idle = (chunks_sent >= 700) && (chunks_sent < 1000);
            pick = $urandom_range(99);
            if (pick < 65) begin
                send_string($urandom_range(48));
            end else if (pick < 75) begin
                send_string($urandom_range(200));
            end else if (pick < 85) begin
                send_truncated(REMAIN_W'($urandom), $urandom_range(3, 1));
            end else if (pick < 95) begin
                // noise chunk with any length and flag
                send_chunk(($urandom_range(1) == 1) ? REMAIN_W'($urandom)
                                                    : REMAIN_W'($urandom_range(8)),
                           1'($urandom), BYTE_W'($urandom), BYTE_W'($urandom),
                           BYTE_W'($urandom), BYTE_W'($urandom));
            end else begin
                // final chunk with no first chunk
                send_chunk(REMAIN_W'($urandom_range(FINAL_MAX)), 1'b0, BYTE_W'($urandom),
                           BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom));
            end
        end
        no_idle = 1'b0;
        in_valid <= 1'b0;

        // drain outstanding hashes, then let the block settle
        while (hashes_pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);

        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
